>>> hdl/line_syntax_highlighter_defines.svh
// Assertion macros used by the top level of the line syntax highlighter RTL.
`ifndef LINE_SYNTAX_HIGHLIGHTER_DEFINES_SVH
`define LINE_SYNTAX_HIGHLIGHTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LSH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LSH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/lsh_pkg.sv
// Types, constants and helper functions for the line syntax highlighter.
package lsh_pkg;

  localparam int MAX_OPENER_LEN = 4;
  localparam int TEXT_BYTES     = 4;
  localparam int LEN_CAP        = (MAX_OPENER_LEN < TEXT_BYTES) ? MAX_OPENER_LEN : TEXT_BYTES;
  localparam int CNT_W          = $clog2(MAX_OPENER_LEN + 1);
  localparam int IDX_W          = (MAX_OPENER_LEN > 1) ? $clog2(MAX_OPENER_LEN) : 1;
  localparam int CHAR_W         = 8;
  localparam int ADDR_W         = 5;
  localparam int DATA_W         = 32;

  // Register indexes (byte address divided by four).
  localparam logic [2:0] REG_SYNTAX_ON    = 3'd0;
  localparam logic [2:0] REG_STRINGS_ON   = 3'd1;
  localparam logic [2:0] REG_NUMBERS_ON   = 3'd2;
  localparam logic [2:0] REG_COMMENT_LEN  = 3'd3;
  localparam logic [2:0] REG_COMMENT_TEXT = 3'd4;

  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_DIGIT0 = 8'h30;
  localparam logic [CHAR_W-1:0] CH_DIGIT9 = 8'h39;

  typedef enum logic [1:0] {
    CLS_NORMAL  = 2'd0,
    CLS_COMMENT = 2'd1,
    CLS_STRING  = 2'd2,
    CLS_NUMBER  = 2'd3
  } char_class_t;

  typedef struct packed {
    logic        syntax_on;
    logic        strings_on;
    logic        numbers_on;
    logic [2:0]  comment_len;
    logic [31:0] comment_text;
  } cfg_t;

  // Oldest held character and what the lookahead knows about it.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              match;
    logic              is_final;
  } head_t;

  typedef struct packed {
    logic             emit_req;
    logic             flush;
    logic             ready;
  } la_stat_t;

  function automatic logic is_separator(input logic [CHAR_W-1:0] c);
    logic sep;
    case (c)
      8'h00, 8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: sep = 1'b1;
      8'h2C, 8'h2E, 8'h28, 8'h29, 8'h2B, 8'h2D, 8'h2F, 8'h2A: sep = 1'b1;
      8'h3D, 8'h7E, 8'h25, 8'h3C, 8'h3E, 8'h5B, 8'h5D, 8'h3B: sep = 1'b1;
      default: sep = 1'b0;
    endcase
    return sep;
  endfunction

  // Effective opener length: zero when highlighting is off, capped otherwise.
  function automatic logic [CNT_W-1:0] opener_len(input cfg_t cfg);
    logic [CNT_W-1:0] len;
    if (!cfg.syntax_on) begin
      len = '0;
    end else if (int'(cfg.comment_len) > LEN_CAP) begin
      len = CNT_W'(LEN_CAP);
    end else begin
      len = CNT_W'(cfg.comment_len);
    end
    return len;
  endfunction

endpackage

>>> hdl/lsh_in_if.sv
// Input channel: one character of a text line per request.
interface lsh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last_char;

  modport source (output valid, ch, last_char, input ready);
  modport sink   (input valid, ch, last_char, output ready);
endinterface

>>> hdl/lsh_out_if.sv
// Result channel: one character class per request.
interface lsh_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] char_class;
  logic       line_end;

  modport source (output valid, char_class, line_end, input ready);
  modport sink   (input valid, char_class, line_end, output ready);
endinterface

>>> hdl/line_syntax_highlighter.sv
// Top level of the line syntax highlighter.
// The block classifies the characters of a text line as normal, comment, string or number,
// one character per request on the input channel and one class per request on the result
// channel, in the order the characters arrived. The sustained rate is one character per
// clock cycle while the output is not stalled and no line end drains. To compare a comment
// opener of L characters, up to L-1 characters are held in a four-entry lookahead register
// before their class is known; at the end of a line the held characters drain one per
// cycle through the output register, barring stalls, and the first character of the next
// line is taken in the cycle that the final class of the current line moves to the
// output. After an opener match, the characters held behind it also leave one per cycle,
// barring stalls. Each class passes through the lookahead and the output register, and
// when the opener hold-back applies it also waits for L-1 later characters. The output
// register lets the input keep taking characters while a class waits to be taken, until
// the lookahead is full. With highlighting off nothing is held back and every class is
// normal. Configuration must be written over the APB port between lines; the block does
// not enforce this. Register i sits at byte address 4*i and reads back its value.
`include "line_syntax_highlighter_defines.svh"

module line_syntax_highlighter (
  input  logic                       clk,
  input  logic                       rst_n,
  lsh_in_if.sink                     in_chan,
  lsh_out_if.source                  out_chan,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lsh_pkg::ADDR_W-1:0] paddr,
  input  logic [lsh_pkg::DATA_W-1:0] pwdata,
  output logic [lsh_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  lsh_pkg::cfg_t        cfg;
  lsh_pkg::head_t       head;
  lsh_pkg::la_stat_t    stat;
  lsh_pkg::char_class_t cls;
  logic                 comment_active;
  logic                 push;
  logic                 pop;

  logic                 out_valid_r;
  lsh_pkg::char_class_t out_class_r;
  logic                 out_end_r;

  // A character enters the lookahead when it has room and no line is draining, or as the drain's final class leaves.
  assign in_chan.ready = stat.ready;
  assign push          = in_chan.valid && stat.ready;

  // The head leaves when it is ready to be classified and the output register
  // is empty or being emptied in this cycle.
  assign pop = stat.emit_req && (!out_valid_r || out_chan.ready);

  lsh_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lsh_lookahead u_lookahead (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .push           (push),
    .push_ch        (in_chan.ch),
    .push_last      (in_chan.last_char),
    .pop            (pop),
    .comment_active (comment_active),
    .head           (head),
    .stat           (stat)
  );

  lsh_classify u_classify (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .head           (head),
    .pop            (pop),
    .cls            (cls),
    .comment_active (comment_active)
  );

  // Output register: the class of the character that just left the lookahead.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_class_r <= cls;
      out_end_r   <= head.is_final;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.char_class = out_class_r;
  assign out_chan.line_end   = out_end_r;

  // A waiting class that is not taken must not be overwritten.
  `LSH_ASSERT_NOW(a_no_pop_when_stalled, clk, rst_n,
                  out_chan.valid && !out_chan.ready, !pop,
                  "class overwritten while output stalled")
  // During an end-of-line drain, a new character is only taken with the final class.
  `LSH_ASSERT_NOW(a_flush_accept, clk, rst_n,
                  push && stat.flush, pop && head.is_final,
                  "character taken during line drain")
  // The final character of a line always leaves the comment state cleared.
  `LSH_ASSERT_NEXT(a_final_clears, clk, rst_n,
                   pop && head.is_final, !comment_active,
                   "comment state survived line end")

endmodule

>>> hdl/lsh_cfg.sv
// APB-style configuration registers of the line syntax highlighter.
module lsh_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lsh_pkg::ADDR_W-1:0] paddr,
  input  logic [lsh_pkg::DATA_W-1:0] pwdata,
  output logic [lsh_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output lsh_pkg::cfg_t              cfg
);

  lsh_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [2:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        lsh_pkg::REG_SYNTAX_ON:    cfg_r.syntax_on    <= pwdata[0];
        lsh_pkg::REG_STRINGS_ON:   cfg_r.strings_on   <= pwdata[0];
        lsh_pkg::REG_NUMBERS_ON:   cfg_r.numbers_on   <= pwdata[0];
        lsh_pkg::REG_COMMENT_LEN:  cfg_r.comment_len  <= pwdata[2:0];
        lsh_pkg::REG_COMMENT_TEXT: cfg_r.comment_text <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lsh_pkg::REG_SYNTAX_ON:    prdata = {31'd0, cfg_r.syntax_on};
      lsh_pkg::REG_STRINGS_ON:   prdata = {31'd0, cfg_r.strings_on};
      lsh_pkg::REG_NUMBERS_ON:   prdata = {31'd0, cfg_r.numbers_on};
      lsh_pkg::REG_COMMENT_LEN:  prdata = {29'd0, cfg_r.comment_len};
      lsh_pkg::REG_COMMENT_TEXT: prdata = cfg_r.comment_text;
      default:                   prdata = '0;
    endcase
  end

endmodule

>>> hdl/lsh_lookahead.sv
// Holds back characters for the comment opener compare and decides when the head may go out.
module lsh_lookahead (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lsh_pkg::cfg_t              cfg,
  input  logic                       push,
  input  logic [lsh_pkg::CHAR_W-1:0] push_ch,
  input  logic                       push_last,
  input  logic                       pop,
  input  logic                       comment_active,
  output lsh_pkg::head_t             head,
  output lsh_pkg::la_stat_t          stat
);

  localparam int MAXL = lsh_pkg::MAX_OPENER_LEN;
  localparam int CW   = lsh_pkg::CNT_W;

  logic [lsh_pkg::CHAR_W-1:0] look_r [MAXL];
  logic [CW-1:0]              pending_r, pending_nxt;
  logic                       flush_r, flush_nxt;
  logic [CW-1:0]              len, hold;
  logic [CW-1:0]              after_pop;
  logic [lsh_pkg::IDX_W-1:0]  widx;
  logic                       final_pop;
  logic                       match;

  assign len       = lsh_pkg::opener_len(cfg);
  assign hold      = (len == '0) ? '0 : len - CW'(1);
  assign final_pop = pop && flush_r && (pending_r == CW'(1));
  assign after_pop = pending_r - CW'(pop);
  assign widx      = lsh_pkg::IDX_W'(after_pop);

  // Opener compare over the held characters; needs a full opener's worth present.
  always_comb begin
    match = (len != '0) && (pending_r >= len);
    for (int k = 0; k < lsh_pkg::LEN_CAP; k++) begin
      if ((CW'(k) < len) && (look_r[k] != cfg.comment_text[8*k +: 8])) begin
        match = 1'b0;
      end
    end
  end

  assign head.ch       = look_r[0];
  assign head.match    = match;
  assign head.is_final = flush_r && (pending_r == CW'(1));

  assign stat.emit_req = (pending_r != '0) && (flush_r || comment_active || (pending_r > hold));
  assign stat.flush    = flush_r;
  assign stat.ready    = ((pending_r != CW'(MAXL)) || pop) && (!flush_r || final_pop);

  always_comb begin
    pending_nxt = after_pop + CW'(push);
    flush_nxt   = flush_r;
    if (push && push_last) begin
      flush_nxt = 1'b1;
    end else if (final_pop) begin
      flush_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      flush_r   <= 1'b0;
    end else begin
      pending_r <= pending_nxt;
      flush_r   <= flush_nxt;
    end
  end

  // Entries take the new character in the write slot; all but the last shift on a pop.
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAXL - 1; i++) begin
      if (push && (widx == lsh_pkg::IDX_W'(i))) begin
        look_r[i] <= push_ch;
      end else if (pop) begin
        look_r[i] <= look_r[i+1];
      end
    end
    if (push && (widx == lsh_pkg::IDX_W'(MAXL - 1))) begin
      look_r[MAXL-1] <= push_ch;
    end
  end

endmodule

>>> hdl/lsh_classify.sv
// Per-line highlight state and the class decision for the character at the head.
module lsh_classify (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lsh_pkg::cfg_t        cfg,
  input  lsh_pkg::head_t       head,
  input  logic                 pop,
  output lsh_pkg::char_class_t cls,
  output logic                 comment_active
);

  logic [lsh_pkg::CHAR_W-1:0] open_quote_r, open_quote_nxt;
  logic                       after_sep_r, after_sep_nxt;
  lsh_pkg::char_class_t       prior_r, prior_nxt;
  logic                       escape_r, escape_nxt;
  logic                       comment_r, comment_nxt;
  logic [lsh_pkg::CHAR_W-1:0] c;
  logic                       is_digit;

  assign c              = head.ch;
  assign is_digit       = (c >= lsh_pkg::CH_DIGIT0) && (c <= lsh_pkg::CH_DIGIT9);
  assign comment_active = comment_r;

  always_comb begin
    open_quote_nxt = open_quote_r;
    after_sep_nxt  = after_sep_r;
    prior_nxt      = prior_r;
    escape_nxt     = escape_r;
    comment_nxt    = comment_r;
    cls            = lsh_pkg::CLS_NORMAL;

    if (!cfg.syntax_on) begin
      cls = lsh_pkg::CLS_NORMAL;
    end else if (comment_r) begin
      cls = lsh_pkg::CLS_COMMENT;
    end else if (head.match && (open_quote_r == lsh_pkg::CH_NUL)) begin
      comment_nxt = 1'b1;
      prior_nxt   = lsh_pkg::CLS_COMMENT;
      cls         = lsh_pkg::CLS_COMMENT;
    end else if (cfg.strings_on && (open_quote_r != lsh_pkg::CH_NUL)) begin
      if (escape_r) begin
        escape_nxt = 1'b0;
      end else if ((c == lsh_pkg::CH_BSLASH) && !head.is_final) begin
        escape_nxt = 1'b1;
      end else begin
        if (c == open_quote_r) begin
          open_quote_nxt = lsh_pkg::CH_NUL;
        end
        after_sep_nxt = 1'b0;
      end
      prior_nxt = lsh_pkg::CLS_STRING;
      cls       = lsh_pkg::CLS_STRING;
    end else if (cfg.strings_on && ((c == lsh_pkg::CH_DQUOTE) || (c == lsh_pkg::CH_SQUOTE))) begin
      open_quote_nxt = c;
      prior_nxt      = lsh_pkg::CLS_STRING;
      cls            = lsh_pkg::CLS_STRING;
    end else if (cfg.numbers_on &&
                 ((is_digit && (after_sep_r || (prior_r == lsh_pkg::CLS_NUMBER))) ||
                  ((c == lsh_pkg::CH_DOT) && (prior_r == lsh_pkg::CLS_NUMBER)))) begin
      after_sep_nxt = 1'b0;
      prior_nxt     = lsh_pkg::CLS_NUMBER;
      cls           = lsh_pkg::CLS_NUMBER;
    end else begin
      after_sep_nxt = lsh_pkg::is_separator(c);
      prior_nxt     = lsh_pkg::CLS_NORMAL;
      cls           = lsh_pkg::CLS_NORMAL;
    end
  end

  // The line's final character returns everything to the start-of-line state.
  always_ff @(posedge clk) begin
    if (!rst_n || (pop && head.is_final)) begin
      open_quote_r <= lsh_pkg::CH_NUL;
      after_sep_r  <= 1'b1;
      prior_r      <= lsh_pkg::CLS_NORMAL;
      escape_r     <= 1'b0;
      comment_r    <= 1'b0;
    end else if (pop) begin
      open_quote_r <= open_quote_nxt;
      after_sep_r  <= after_sep_nxt;
      prior_r      <= prior_nxt;
      escape_r     <= escape_nxt;
      comment_r    <= comment_nxt;
    end
  end

endmodule

>>> tb/tb.sv
// Self-checking testbench for the line syntax highlighter: directed and random lines.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles before the run is declared hung. The slowest legal run is far below this.
  localparam int LIMIT_CYCLES = 200000;
  // Cycles of the receiver's long hold-off, long enough to back the block up.
  localparam int LONG_HOLD = 300;
  // Idle cycles after the last class arrives, covering the lookahead drain.
  localparam int SETTLE_CYCLES = 12;

  typedef struct {
    logic [7:0] ch;
    bit         last;
  } char_req_t;

  typedef struct {
    lsh_pkg::char_class_t cls;
    bit                   fin;
  } class_res_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [lsh_pkg::ADDR_W-1:0] paddr;
  logic [lsh_pkg::DATA_W-1:0] pwdata;
  logic [lsh_pkg::DATA_W-1:0] prdata;
  logic pready;

  lsh_in_if  in_bus ();
  lsh_out_if out_bus ();

  line_syntax_highlighter uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Characters waiting to be offered, and classes the block still owes us.
  char_req_t  pending_chars[$];
  class_res_t due_classes[$];

  // Handshake flags, sampled at the rising edge and used by the drivers at the falling edge.
  bit in_acc;
  bit out_acc;

  // Idle control for both sides.
  int in_gap;
  int out_wait;
  bit in_steady;
  bit out_steady;
  int hold_left;
  bit hold_armed;
  char_req_t drive_char;

  int fail_count;
  int cycle_count;

  // Shadow of the configuration registers, updated at the edge that writes them.
  lsh_pkg::cfg_t cfg_now;

  // Predictor state: the lookahead store and the per-line scanner state.
  logic [7:0]           hold_buf[lsh_pkg::MAX_OPENER_LEN];
  int unsigned          held_n;
  logic [7:0]           quote_ch;
  bit                   after_sep;
  lsh_pkg::char_class_t prev_cls;
  bit                   esc;
  bit                   in_comment;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycles a side waits before its next request; zero through a steady stretch.
  function automatic int draw_wait(input bit steady);
    return steady ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic bit sep_char(input logic [7:0] c);
    string punct = ",.()+-/*=~%<>[];";
    if (c == 8'h00 || c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) return 1'b1;
    for (int k = 0; k < punct.len(); k++) begin
      if (punct[k] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Everything but the lookahead contents returns to its start value at a line end.
  function automatic void clear_line();
    held_n     = 0;
    quote_ch   = lsh_pkg::CH_NUL;
    after_sep  = 1'b1;
    prev_cls   = lsh_pkg::CLS_NORMAL;
    esc        = 1'b0;
    in_comment = 1'b0;
  endfunction

  // Class of the oldest held character; fin marks it as the final one of its line.
  function automatic lsh_pkg::char_class_t classify_front(input int unsigned len,
                                                          input bit fin);
    logic [7:0]           c;
    bit                   hit;
    lsh_pkg::char_class_t cls;
    c   = hold_buf[0];
    cls = lsh_pkg::CLS_NORMAL;
    if (!cfg_now.syntax_on) return lsh_pkg::CLS_NORMAL;
    if (in_comment) return lsh_pkg::CLS_COMMENT;

    // The opener is only looked for outside a string and with enough characters held.
    if (len > 0 && quote_ch == lsh_pkg::CH_NUL && held_n >= len) begin
      hit = 1'b1;
      for (int k = 0; k < len; k++) begin
        if (hold_buf[k] != cfg_now.comment_text[8*k +: 8]) hit = 1'b0;
      end
      if (hit) begin
        in_comment = 1'b1;
        prev_cls   = lsh_pkg::CLS_COMMENT;
        return lsh_pkg::CLS_COMMENT;
      end
    end

    if (cfg_now.strings_on) begin
      if (quote_ch != lsh_pkg::CH_NUL) begin
        // A backslash on the final character of a line carries no escape.
        if (esc) begin
          esc = 1'b0;
        end else if (c == lsh_pkg::CH_BSLASH && !fin) begin
          esc = 1'b1;
        end else begin
          if (c == quote_ch) quote_ch = lsh_pkg::CH_NUL;
          after_sep = 1'b0;
        end
        prev_cls = lsh_pkg::CLS_STRING;
        return lsh_pkg::CLS_STRING;
      end
      if (c == lsh_pkg::CH_DQUOTE || c == lsh_pkg::CH_SQUOTE) begin
        quote_ch = c;
        prev_cls = lsh_pkg::CLS_STRING;
        return lsh_pkg::CLS_STRING;
      end
    end

    if (cfg_now.numbers_on &&
        (((c >= lsh_pkg::CH_DIGIT0 && c <= lsh_pkg::CH_DIGIT9) &&
          (after_sep || prev_cls == lsh_pkg::CLS_NUMBER)) ||
         (c == lsh_pkg::CH_DOT && prev_cls == lsh_pkg::CLS_NUMBER))) begin
      cls       = lsh_pkg::CLS_NUMBER;
      after_sep = 1'b0;
    end else begin
      after_sep = sep_char(c);
    end
    prev_cls = cls;
    return cls;
  endfunction

  // Takes one accepted character and queues every class it releases.
  function automatic void take_char(input logic [7:0] c, input bit last);
    int unsigned len;
    int unsigned keep;
    bit          fin;
    class_res_t  res;
    if (held_n >= lsh_pkg::MAX_OPENER_LEN) held_n = lsh_pkg::MAX_OPENER_LEN - 1;
    hold_buf[held_n] = c;
    held_n++;

    // The opener length is capped by the store depth and by the four text bytes.
    len = cfg_now.comment_len;
    if (len > lsh_pkg::MAX_OPENER_LEN) len = lsh_pkg::MAX_OPENER_LEN;
    if (len > 4) len = 4;
    if (!cfg_now.syntax_on) len = 0;
    keep = (len > 0) ? len - 1 : 0;

    while (held_n > 0 && (last || in_comment || held_n > keep)) begin
      fin     = last && held_n == 1;
      res.cls = classify_front(len, fin);
      res.fin = fin;
      due_classes.push_back(res);
      for (int k = 0; k < lsh_pkg::MAX_OPENER_LEN - 1; k++) hold_buf[k] = hold_buf[k+1];
      held_n--;
    end
    if (last) clear_line();
  endfunction

  function automatic void push_char(input logic [7:0] c, input bit last);
    char_req_t req;
    req.ch   = c;
    req.last = last;
    pending_chars.push_back(req);
  endfunction

  // Queues a printable line; its final character carries the end-of-line mark.
  function automatic void push_text(input string s);
    for (int k = 0; k < s.len(); k++) push_char(s[k], k == s.len() - 1);
  endfunction

  // One APB write: setup cycle, then the access cycle that commits at the rising edge.
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      lsh_pkg::REG_SYNTAX_ON:    cfg_now.syntax_on    = val[0];
      lsh_pkg::REG_STRINGS_ON:   cfg_now.strings_on   = val[0];
      lsh_pkg::REG_NUMBERS_ON:   cfg_now.numbers_on   = val[0];
      lsh_pkg::REG_COMMENT_LEN:  cfg_now.comment_len  = val[2:0];
      lsh_pkg::REG_COMMENT_TEXT: cfg_now.comment_text = val;
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_cfg(input bit syn, input bit str, input bit num,
                           input logic [2:0] clen, input logic [31:0] txt);
    cfg_write(lsh_pkg::REG_SYNTAX_ON, {31'd0, syn});
    cfg_write(lsh_pkg::REG_STRINGS_ON, {31'd0, str});
    cfg_write(lsh_pkg::REG_NUMBERS_ON, {31'd0, num});
    cfg_write(lsh_pkg::REG_COMMENT_LEN, {29'd0, clen});
    cfg_write(lsh_pkg::REG_COMMENT_TEXT, txt);
  endtask

  // Waits until every character is taken and every class has come back, then lets
  // the lookahead settle so that a register write cannot land on work in flight.
  task automatic drain();
    while (pending_chars.size() != 0 || in_bus.valid || due_classes.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Monitor: predicts on each accepted character and checks each accepted class.
  // Both happen here so that the order of the two within one edge is fixed.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_acc  = 1'b0;
      out_acc = 1'b0;
      clear_line();
    end else begin
      in_acc  = in_bus.valid && in_bus.ready;
      out_acc = out_bus.valid && out_bus.ready;
      if (in_acc) take_char(in_bus.ch, in_bus.last_char);
      if (out_acc) begin
        if (due_classes.size() == 0) begin
          $display("%0t: class with no character pending: expected none, actual class %0d end %0d",
                   $time, out_bus.char_class, out_bus.line_end);
          fail_count++;
        end else begin
          if (out_bus.char_class !== due_classes[0].cls) begin
            $display("%0t: char_class mismatch: expected %0d, actual %0d",
                     $time, due_classes[0].cls, out_bus.char_class);
            fail_count++;
          end
          if (out_bus.line_end !== due_classes[0].fin) begin
            $display("%0t: line_end mismatch: expected %0d, actual %0d",
                     $time, due_classes[0].fin, out_bus.line_end);
            fail_count++;
          end
          void'(due_classes.pop_front());
        end
      end
    end
  end

  // Character driver: after each accepted request it draws a gap, then offers the
  // next queued character. valid stays high across back-to-back requests.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_acc) begin
        if ($urandom_range(0, 31) == 0) in_steady = !in_steady;
        in_gap = draw_wait(in_steady);
      end
      if (!in_bus.valid || in_acc) begin
        if (in_gap > 0) begin
          in_gap--;
          in_bus.valid <= 1'b0;
        end else if (pending_chars.size() > 0) begin
          drive_char = pending_chars.pop_front();
          in_bus.valid     <= 1'b1;
          in_bus.ch        <= drive_char.ch;
          in_bus.last_char <= drive_char.last;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Class receiver: waits a drawn number of cycles before each request, and keeps
  // ready low for the whole of a long hold-off.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_acc) begin
        if ($urandom_range(0, 31) == 0) out_steady = !out_steady;
        out_wait = draw_wait(out_steady);
      end
      if (hold_left > 0) begin
        out_bus.ready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Long hold-off: once armed, it starts when a character is on offer and counts
  // down while the sender keeps pushing, so the block fills and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
    end else if (hold_armed && in_bus.valid) begin
      hold_left  = LONG_HOLD;
      hold_armed = 1'b0;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int         n;
    int         llen;
    int         r;
    int         cap;
    int         j;
    bit         syn;
    bit         str;
    bit         num;
    logic [2:0] clen;
    logic [31:0] txt;
    logic [7:0] line_buf[$];
    string      seps_pool;
    string      opener_pool;

    seps_pool   = " ,.()+-/*=~%<>[];\t";
    opener_pool = "/#-;*!";

    // Every input known from time zero while reset is held.
    rst_n         = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_bus.valid  = 1'b0;
    in_bus.ch     = '0;
    in_bus.last_char = 1'b0;
    out_bus.ready = 1'b0;
    cfg_now       = '0;
    fail_count    = 0;
    cycle_count   = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Syntax off after reset: the extreme byte values pass straight through as normal.
    push_char(8'hFF, 1'b0);
    push_char(lsh_pkg::CH_NUL, 1'b1);
    drain();

    // Two-character opener. The first line has a number with a dot, a string with an
    // escaped quote and the other quote inside it, then a comment to the end of line.
    // The second ends on a backslash inside a string; the third has half an opener
    // as its final character, which must not match.
    apply_cfg(1'b1, 1'b1, 1'b1, 3'd2, 32'h0000_2F2F);
    push_text("(1.5\"\\\"'\"//z");
    push_text("\"a\\");
    push_text("x/");
    drain();

    // Opener length above the cap, and an opener with a zero byte in it.
    apply_cfg(1'b1, 1'b1, 1'b1, 3'd7, 32'h2300_2D3B);
    push_char(8'h3B, 1'b0);
    push_char(8'h2D, 1'b0);
    push_char(lsh_pkg::CH_NUL, 1'b0);
    push_char(8'h23, 1'b1);
    drain();

    // Random phases, each with its own configuration. The phase number forces the
    // extremes: no opener, the longest, one above the cap, syntax off with an opener
    // set, strings off and numbers off.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: clen = 3'd2;
        1: clen = 3'd0;
        2: clen = 3'd1;
        3: clen = 3'd4;
        4: clen = 3'd7;
        5: clen = 3'd3;
        6: clen = 3'd5;
        default: clen = 3'($urandom_range(0, 7));
      endcase
      syn = (p != 5);
      str = (p != 2);
      num = (p != 3);
      if (p == 7) begin
        syn = 1'($urandom_range(0, 1));
        str = 1'($urandom_range(0, 1));
        num = 1'($urandom_range(0, 1));
      end
      if ($urandom_range(0, 1) == 0) begin
        txt = $urandom();
      end else begin
        for (int k = 0; k < 4; k++)
          txt[8*k +: 8] = opener_pool[$urandom_range(0, opener_pool.len() - 1)];
      end
      apply_cfg(syn, str, num, clen, txt);

      cap = (clen > 4) ? 4 : clen;
      if (cap == 0) cap = 1;

      // Whole lines only, so the phase ends with the block idle. Openers, partial
      // openers, quotes, backslashes, digits and dots dominate; the rest is noise.
      n = 0;
      while (n < 30) begin
        llen = $urandom_range(1, 14);
        line_buf.delete();
        while (line_buf.size() < llen) begin
          r = $urandom_range(0, 99);
          if (r < 12) begin
            j = $urandom_range(1, cap);
            for (int k = 0; k < j; k++) line_buf.push_back(txt[8*k +: 8]);
          end else if (r < 22) begin
            line_buf.push_back(($urandom_range(0, 1) != 0) ? lsh_pkg::CH_DQUOTE
                                                            : lsh_pkg::CH_SQUOTE);
          end else if (r < 28) begin
            line_buf.push_back(lsh_pkg::CH_BSLASH);
          end else if (r < 46) begin
            line_buf.push_back(8'(lsh_pkg::CH_DIGIT0 + $urandom_range(0, 9)));
          end else if (r < 54) begin
            line_buf.push_back(lsh_pkg::CH_DOT);
          end else if (r < 68) begin
            line_buf.push_back(seps_pool[$urandom_range(0, seps_pool.len() - 1)]);
          end else if (r < 78) begin
            line_buf.push_back(8'(8'h61 + $urandom_range(0, 25)));
          end else begin
            line_buf.push_back(8'($urandom_range(0, 255)));
          end
        end
        for (int k = 0; k < line_buf.size(); k++)
          push_char(line_buf[k], k == line_buf.size() - 1);
        n += line_buf.size();
      end

      // The first random phase carries the long receiver hold-off.
      if (p == 0) hold_armed = 1'b1;
      drain();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
